// ===== sv/sbf_pkg.sv =====
// ----------------------------------------------------------------------------
// sbf_pkg
// Shared types and constants for the spring / bungee force unit.
// ----------------------------------------------------------------------------
package sbf_pkg;

  // Coordinate and force width, signed fixed point
  localparam int COORD_W = 32;
  // Default fraction bits of the fixed point format
  localparam int FRAC_DEF = 16;
  // Width of the configuration registers and of the write data
  localparam int CFG_W = 31;
  localparam int CFG_IDX_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_K    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REST = 2'd2;

  // Mode codes
  localparam logic MODE_SPRING = 1'b0;
  localparam logic MODE_BUNGEE = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] self_x;
    logic signed [COORD_W-1:0] self_y;
    logic signed [COORD_W-1:0] self_z;
    logic signed [COORD_W-1:0] other_x;
    logic signed [COORD_W-1:0] other_y;
    logic signed [COORD_W-1:0] other_z;
  } sbf_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] force_x;
    logic signed [COORD_W-1:0] force_y;
    logic signed [COORD_W-1:0] force_z;
    logic                      force_applied;
    logic                      saturated;
  } sbf_out_t;

endpackage

// ===== sv/sbf_sqrt.sv =====
// ----------------------------------------------------------------------------
// sbf_sqrt
// Pipelined integer square root, one root bit per stage, with side data.
// ----------------------------------------------------------------------------
module sbf_sqrt #(
  parameter int LW  = 33,
  parameter int SBW = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_v,
  input  logic [2*LW-1:0] in_rad,
  input  logic [SBW-1:0]  in_side,
  output logic            out_v,
  output logic [LW-1:0]   out_root,
  output logic [SBW-1:0]  out_side
);
  localparam int RW = LW + 2;

  logic [LW-1:0]   vld_r;
  logic [RW-1:0]   rem_r  [LW];
  logic [LW-1:0]   root_r [LW];
  logic [2*LW-1:0] rad_r  [LW];
  logic [SBW-1:0]  side_r [LW];

  for (genvar g = 0; g < LW; g++) begin : g_stage
    logic            vld_i;
    logic [RW-1:0]   rem_i;
    logic [LW-1:0]   root_i;
    logic [2*LW-1:0] rad_i;
    logic [SBW-1:0]  side_i;
    logic [RW-1:0]   acc;
    logic [RW-1:0]   trial;
    logic            ge;

    if (g == 0) begin : g_first
      assign vld_i  = in_v;
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = in_rad;
      assign side_i = in_side;
    end else begin : g_next
      assign vld_i  = vld_r[g-1];
      assign rem_i  = rem_r[g-1];
      assign root_i = root_r[g-1];
      assign rad_i  = rad_r[g-1];
      assign side_i = side_r[g-1];
    end

    // Bring down two radicand bits and try the next root bit
    assign acc   = {rem_i[RW-3:0], rad_i[2*LW-1 -: 2]};
    assign trial = {root_i, 2'b01};
    assign ge    = (acc >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= ge ? (acc - trial) : acc;
        root_r[g] <= {root_i[LW-2:0], ge};
        rad_r[g]  <= rad_i << 2;
        side_r[g] <= side_i;
      end
    end
  end

  assign out_v    = vld_r[LW-1];
  assign out_root = root_r[LW-1];
  assign out_side = side_r[LW-1];

endmodule

// ===== sv/sbf_div.sv =====
// ----------------------------------------------------------------------------
// sbf_div
// Pipelined restoring divider, several lanes over one shared divisor,
// one quotient bit per stage. The quotient must fit in QW bits.
// ----------------------------------------------------------------------------
module sbf_div #(
  parameter int NL  = 3,
  parameter int NW  = 49,
  parameter int DVW = 33,
  parameter int QW  = 17,
  parameter int SBW = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_v,
  input  logic [NL-1:0][NW-1:0]  in_num,
  input  logic [DVW-1:0]         in_dvs,
  input  logic [SBW-1:0]         in_side,
  output logic                   out_v,
  output logic [NL-1:0][QW-1:0]  out_quo,
  output logic [SBW-1:0]         out_side
);
  logic [QW-1:0]               vld_r;
  logic [NL-1:0][DVW-1:0]      rem_r  [QW];
  logic [NL-1:0][QW-1:0]       quo_r  [QW];
  logic [NL-1:0][QW-1:0]       low_r  [QW];
  logic [DVW-1:0]              dvs_r  [QW];
  logic [SBW-1:0]              side_r [QW];

  for (genvar g = 0; g < QW; g++) begin : g_stage
    logic                  vld_i;
    logic [NL-1:0][DVW-1:0] rem_i;
    logic [NL-1:0][QW-1:0]  quo_i;
    logic [NL-1:0][QW-1:0]  low_i;
    logic [DVW-1:0]         dvs_i;
    logic [SBW-1:0]         side_i;
    logic [NL-1:0][DVW-1:0] rem_o;
    logic [NL-1:0][QW-1:0]  quo_o;

    if (g == 0) begin : g_first
      assign vld_i  = in_v;
      assign dvs_i  = in_dvs;
      assign side_i = in_side;
      for (genvar l = 0; l < NL; l++) begin : g_ln
        assign rem_i[l] = DVW'(in_num[l][NW-1:QW]);
        assign quo_i[l] = '0;
        assign low_i[l] = in_num[l][QW-1:0];
      end
    end else begin : g_next
      assign vld_i  = vld_r[g-1];
      assign rem_i  = rem_r[g-1];
      assign quo_i  = quo_r[g-1];
      assign low_i  = low_r[g-1];
      assign dvs_i  = dvs_r[g-1];
      assign side_i = side_r[g-1];
    end

    // Shift in the next numerator bit and subtract where it fits
    always_comb begin
      logic [DVW:0] acc;
      logic         ge;
      for (int l = 0; l < NL; l++) begin
        acc      = {rem_i[l], low_i[l][QW-1]};
        ge       = (acc >= {1'b0, dvs_i});
        rem_o[l] = ge ? DVW'(acc - {1'b0, dvs_i}) : DVW'(acc);
        quo_o[l] = {quo_i[l][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= rem_o;
        quo_r[g]  <= quo_o;
        for (int l = 0; l < NL; l++) begin
          low_r[g][l] <= low_i[l] << 1;
        end
        dvs_r[g]  <= dvs_i;
        side_r[g] <= side_i;
      end
    end
  end

  assign out_v    = vld_r[QW-1];
  assign out_quo  = quo_r[QW-1];
  assign out_side = side_r[QW-1];

endmodule

// ===== sv/spring_bungee_force.sv =====
// ----------------------------------------------------------------------------
// spring_bungee_force
// Hooke spring / bungee force vector in signed fixed point.
// ----------------------------------------------------------------------------
// Takes one position pair per cycle while the output is not held and returns
// the force on the particle, -k*m*d/|d| with d = self - other and m the
// stretch (spring: |L-rest|, bungee: L-rest when stretched, none when slack).
// A request passes through four stages of difference, magnitude, squares and
// sum, a square root with one root bit per stage, the stretch and stiffness
// product, a divider with one quotient bit per stage for the unit direction,
// the scaling product and the output clamp. The whole pipeline holds while a
// result waits under out_stall. Write configuration only while the pipeline
// is empty.
// ----------------------------------------------------------------------------
module spring_bungee_force #(
  parameter int FRAC_BITS = sbf_pkg::FRAC_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  sbf_pkg::sbf_in_t               in_req,
  output logic                           out_valid,
  input  logic                           out_stall,
  output sbf_pkg::sbf_out_t              out_rsp,
  input  logic                           cfg_we,
  input  logic [sbf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sbf_pkg::CFG_W-1:0]      cfg_wdata
);
  import sbf_pkg::*;

  localparam int CW   = COORD_W;
  localparam int DW   = CW + 1;
  localparam int SW   = 2 * DW;
  localparam int MW   = (DW > CFG_W) ? DW : CFG_W;
  localparam int KMW  = CFG_W + MW;
  localparam int MGW  = KMW - FRAC_BITS;
  localparam int QW   = FRAC_BITS + 1;
  localparam int NW   = DW + FRAC_BITS;
  localparam int PMW  = MGW + QW;
  localparam int PW   = PMW - FRAC_BITS;
  localparam int SQSB = 3 * DW + 6;
  localparam int DVSB = MGW + 7;
  localparam logic [PW-1:0] LIM = PW'(1) << (CW - 1);
  localparam logic [CFG_W-1:0] ONE = CFG_W'(1) << FRAC_BITS;

  // Configuration registers
  logic             mode_r;
  logic [CFG_W-1:0] k_r;
  logic [CFG_W-1:0] rest_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_SPRING;
      k_r    <= ONE;
      rest_r <= ONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE: mode_r <= cfg_wdata[0];
        CFG_K:    k_r    <= cfg_wdata;
        CFG_REST: rest_r <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  // Pipeline advance: everything moves unless the output is held
  logic en;
  logic out_valid_r;
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  logic [2:0][CW-1:0] self_c;
  logic [2:0][CW-1:0] other_c;
  assign self_c  = {in_req.self_z, in_req.self_y, in_req.self_x};
  assign other_c = {in_req.other_z, in_req.other_y, in_req.other_x};

  // Stage 1: difference vector
  logic               v1_r;
  logic [2:0][DW-1:0] diff1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        diff1_r[i] <= {self_c[i][CW-1], self_c[i]} - {other_c[i][CW-1], other_c[i]};
      end
    end
  end

  // Stage 2: magnitude, sign and zero flags
  logic               v2_r;
  logic [2:0][DW-1:0] ad2_r;
  logic [2:0]         neg2_r;
  logic [2:0]         nz2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg2_r[i] <= diff1_r[i][DW-1];
        nz2_r[i]  <= (diff1_r[i] != '0);
        ad2_r[i]  <= diff1_r[i][DW-1] ? (DW'(0) - diff1_r[i]) : diff1_r[i];
      end
    end
  end

  // Stage 3: squares
  logic               v3_r;
  logic [2:0][SW-1:0] sq3_r;
  logic [2:0][DW-1:0] ad3_r;
  logic [2:0]         neg3_r;
  logic [2:0]         nz3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq3_r[i] <= SW'(ad2_r[i]) * SW'(ad2_r[i]);
      end
      ad3_r  <= ad2_r;
      neg3_r <= neg2_r;
      nz3_r  <= nz2_r;
    end
  end

  // Stage 4: sum of squares
  logic               v4_r;
  logic [SW-1:0]      sum4_r;
  logic [2:0][DW-1:0] ad4_r;
  logic [2:0]         neg4_r;
  logic [2:0]         nz4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum4_r <= sq3_r[0] + sq3_r[1] + sq3_r[2];
      ad4_r  <= ad3_r;
      neg4_r <= neg3_r;
      nz4_r  <= nz3_r;
    end
  end

  // Length by pipelined square root
  logic               sq_v;
  logic [DW-1:0]      sq_root;
  logic [SQSB-1:0]    sq_side;
  logic [2:0][DW-1:0] adq;
  logic [2:0]         negq;
  logic [2:0]         nzq;

  sbf_sqrt #(
    .LW  (DW),
    .SBW (SQSB)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (v4_r),
    .in_rad   (sum4_r),
    .in_side  ({ad4_r, neg4_r, nz4_r}),
    .out_v    (sq_v),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  assign {adq, negq, nzq} = sq_side;

  // Stage A: stretch and whether a force acts
  logic               vA_r;
  logic [DW-1:0]      lenA_r;
  logic [MW-1:0]      mA_r;
  logic               appA_r;
  logic [2:0][DW-1:0] adA_r;
  logic [2:0]         negA_r;
  logic [2:0]         nzA_r;
  logic [MW-1:0]      len_m;
  logic [MW-1:0]      rest_m;

  assign len_m  = MW'(sq_root);
  assign rest_m = MW'(rest_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vA_r <= 1'b0;
    end else if (en) begin
      vA_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lenA_r <= sq_root;
      mA_r   <= (len_m >= rest_m) ? (len_m - rest_m) : (rest_m - len_m);
      appA_r <= (sq_root != '0) && !((mode_r == MODE_BUNGEE) && (len_m <= rest_m));
      adA_r  <= adq;
      negA_r <= negq;
      nzA_r  <= nzq;
    end
  end

  // Stage B: force magnitude k * stretch
  logic               vB_r;
  logic [MGW-1:0]     magB_r;
  logic [DW-1:0]      lenB_r;
  logic               appB_r;
  logic [2:0][DW-1:0] adB_r;
  logic [2:0]         negB_r;
  logic [2:0]         nzB_r;
  logic [KMW-1:0]     km;

  assign km = KMW'(k_r) * KMW'(mA_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vB_r <= 1'b0;
    end else if (en) begin
      vB_r <= vA_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      magB_r <= km[KMW-1:FRAC_BITS];
      lenB_r <= lenA_r;
      appB_r <= appA_r;
      adB_r  <= adA_r;
      negB_r <= negA_r;
      nzB_r  <= nzA_r;
    end
  end

  // Unit direction |d_i| / L by pipelined division
  logic [2:0][NW-1:0] num;
  logic               dv_v;
  logic [2:0][QW-1:0] dv_quo;
  logic [DVSB-1:0]    dv_side;
  logic [MGW-1:0]     magq;
  logic [2:0]         negd;
  logic [2:0]         nzd;
  logic               appd;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = {adB_r[i], FRAC_BITS'(0)};
    end
  end

  sbf_div #(
    .NL  (3),
    .NW  (NW),
    .DVW (DW),
    .QW  (QW),
    .SBW (DVSB)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (vB_r),
    .in_num   (num),
    .in_dvs   (lenB_r),
    .in_side  ({magB_r, negB_r, nzB_r, appB_r}),
    .out_v    (dv_v),
    .out_quo  (dv_quo),
    .out_side (dv_side)
  );

  assign {magq, negd, nzd, appd} = dv_side;

  // Stage P: scale the direction by the magnitude
  logic               vP_r;
  logic [2:0][PW-1:0] pP_r;
  logic [2:0]         negP_r;
  logic [2:0]         nzP_r;
  logic               appP_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vP_r <= 1'b0;
    end else if (en) begin
      vP_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    logic [PMW-1:0] pm;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pm      = PMW'(magq) * PMW'(dv_quo[i]);
        pP_r[i] <= pm[PMW-1:FRAC_BITS];
      end
      negP_r <= negd;
      nzP_r  <= nzd;
      appP_r <= appd;
    end
  end

  // Output stage: sign, clamp and hold while stalled
  logic [2:0][CW-1:0] fo;
  logic [2:0]         so;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fo[i] = '0;
      so[i] = 1'b0;
      if (appP_r && nzP_r[i]) begin
        if (negP_r[i]) begin
          if (pP_r[i] > LIM - PW'(1)) begin
            fo[i] = CW'(LIM - PW'(1));
            so[i] = 1'b1;
          end else begin
            fo[i] = CW'(pP_r[i]);
          end
        end else begin
          if (pP_r[i] > LIM) begin
            fo[i] = CW'(PW'(0) - LIM);
            so[i] = 1'b1;
          end else begin
            fo[i] = CW'(PW'(0) - pP_r[i]);
          end
        end
      end
    end
  end

  sbf_out_t out_rsp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vP_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rsp_r.force_x       <= fo[0];
      out_rsp_r.force_y       <= fo[1];
      out_rsp_r.force_z       <= fo[2];
      out_rsp_r.force_applied <= appP_r;
      out_rsp_r.saturated     <= |so;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // A slack or zero-length request carries no force and no clamp
  a_no_force: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_rsp_r.force_applied |->
      (out_rsp_r.force_x == '0) && (out_rsp_r.force_y == '0) &&
      (out_rsp_r.force_z == '0) && !out_rsp_r.saturated)
    else $error("force present without force_applied");

  // A clamp only happens on an applied force
  a_sat_applied: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_rsp_r.saturated |-> out_rsp_r.force_applied)
    else $error("saturated without force_applied");

  // Pipeline occupancy freezes while the output is held
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v1_r) && $stable(v4_r) && $stable(vB_r) && $stable(vP_r))
    else $error("pipeline moved while held");

  // A held result stays valid into the next cycle
  a_keep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r)
    else $error("held result dropped");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the spring / bungee force unit.
// ----------------------------------------------------------------------------
// Drives position pairs under several stiffness, rest length and mode
// settings. A scoreboard predicts each force vector in wide integer
// arithmetic and checks every result, in order, field by field. Both
// channels idle in random bursts. One long receiver hold-off backs the
// pipeline up into the input.
// ----------------------------------------------------------------------------
module testbench;
  import sbf_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 120;
  localparam int HOLD_CYCLES = 400;

  // Predicts forces for accepted requests and checks returned results
  class force_scoreboard;
    logic        mode;
    logic [30:0] stiffness;
    logic [30:0] rest;
    sbf_out_t    pending[$];
    int          errors;

    function new();
      mode = MODE_SPRING;
      stiffness = 31'd65536;
      rest = 31'd65536;
      errors = 0;
    endfunction

    function sbf_out_t predict_force(sbf_in_t r);
      logic signed [31:0] s[3];
      logic signed [31:0] o[3];
      logic signed [63:0] d[3];
      logic [127:0] ad[3];
      logic [127:0] sum, res, bitv, len, m, mag, u, p, lim;
      logic [31:0] comp[3];
      logic sat;
      sbf_out_t e;
      s[0] = r.self_x;  s[1] = r.self_y;  s[2] = r.self_z;
      o[0] = r.other_x; o[1] = r.other_y; o[2] = r.other_z;
      sum = '0;
      for (int i = 0; i < 3; i++) begin
        d[i] = 64'(s[i]) - 64'(o[i]);
        ad[i] = d[i] < 0 ? 128'(-d[i]) : 128'(d[i]);
        sum += ad[i] * ad[i];
      end
      // Integer square root, one result bit per pass
      res = '0;
      bitv = 128'd1 << 126;
      while (bitv > sum) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (sum >= res + bitv) begin
          sum = sum - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      len = res;
      e = '0;
      if (len == 0) return e;
      if (mode == MODE_BUNGEE && len <= 128'(rest)) return e;
      m = len >= 128'(rest) ? len - 128'(rest) : 128'(rest) - len;
      mag = (128'(stiffness) * m) >> FRAC_DEF;
      lim = 128'd1 << (COORD_W - 1);
      sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
        u = (ad[i] << FRAC_DEF) / len;
        p = (mag * u) >> FRAC_DEF;
        if (d[i] == 0) begin
          comp[i] = '0;
        end else if (d[i] < 0) begin
          if (p > lim - 1) begin
            comp[i] = 32'h7FFF_FFFF;
            sat = 1'b1;
          end else begin
            comp[i] = p[31:0];
          end
        end else begin
          if (p > lim) begin
            comp[i] = 32'h8000_0000;
            sat = 1'b1;
          end else begin
            comp[i] = -p[31:0];
          end
        end
      end
      e.force_x = comp[0];
      e.force_y = comp[1];
      e.force_z = comp[2];
      e.force_applied = 1'b1;
      e.saturated = sat;
      return e;
    endfunction

    function void note_request(sbf_in_t r);
      pending.insert(pending.size(), predict_force(r));
    endfunction

    function void check_result(sbf_out_t a);
      sbf_out_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.force_x !== a.force_x) begin
        $display("%0t: force_x exp %h got %h", $time, e.force_x, a.force_x);
        errors++;
      end
      if (e.force_y !== a.force_y) begin
        $display("%0t: force_y exp %h got %h", $time, e.force_y, a.force_y);
        errors++;
      end
      if (e.force_z !== a.force_z) begin
        $display("%0t: force_z exp %h got %h", $time, e.force_z, a.force_z);
        errors++;
      end
      if (e.force_applied !== a.force_applied) begin
        $display("%0t: force_applied exp %b got %b", $time, e.force_applied,
                 a.force_applied);
        errors++;
      end
      if (e.saturated !== a.saturated) begin
        $display("%0t: saturated exp %b got %b", $time, e.saturated, a.saturated);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  sbf_in_t in_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sbf_out_t out_rsp;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MODE;
  logic [CFG_W-1:0] cfg_wdata = '0;

  logic idle_on = 1'b1;
  logic hold_req = 1'b0;
  int cycles = 0;
  force_scoreboard sb = new();

  spring_bungee_force dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
    .out_valid(out_valid), .out_stall(out_stall), .out_rsp(out_rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Record accepted requests and check accepted results
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_request(in_req);
      if (out_valid && !out_stall) sb.check_result(out_rsp);
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        out_stall = 1'b1;
        n = $urandom_range(1, 14);
        repeat (n - 1) @(negedge clk);
      end else begin
        out_stall = 1'b0;
        if (idle_on) begin
          n = $urandom_range(1, 14);
          repeat (n - 1) @(negedge clk);
        end
      end
    end
  end

  // Offer one request, hold it until accepted
  task automatic send_request(sbf_in_t r);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_req = r;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
  endtask

  // Drop valid and wait until every result has come back
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_MODE: sb.mode = val[0];
      CFG_K:    sb.stiffness = val;
      CFG_REST: sb.rest = val;
      default: ;
    endcase
  endtask

  task automatic set_config(logic mode, logic [30:0] k, logic [30:0] rest);
    write_reg(CFG_MODE, CFG_W'(mode));
    write_reg(CFG_K, k);
    write_reg(CFG_REST, rest);
  endtask

  function automatic sbf_in_t make_pair(int kind);
    sbf_in_t r;
    int delta;
    r.self_x = $urandom;
    r.self_y = $urandom;
    r.self_z = $urandom;
    r.other_x = $urandom;
    r.other_y = $urandom;
    r.other_z = $urandom;
    case (kind)
      // Nearby ends give forces in range
      2, 3, 4, 5, 6: begin
        delta = int'($urandom_range(0, 2097152)) - 1048576;
        r.other_x = r.self_x + delta;
        delta = int'($urandom_range(0, 2097152)) - 1048576;
        r.other_y = r.self_y + delta;
        delta = int'($urandom_range(0, 2097152)) - 1048576;
        r.other_z = r.self_z + delta;
      end
      // Coincident ends
      7: begin
        r.other_x = r.self_x;
        r.other_y = r.self_y;
        r.other_z = r.self_z;
      end
      // Offset along one axis only
      8: begin
        r.other_y = r.self_y;
        r.other_z = r.self_z;
      end
      // Small coordinates near the origin
      9: begin
        r.self_x = int'($urandom_range(0, 524288)) - 262144;
        r.self_y = int'($urandom_range(0, 524288)) - 262144;
        r.self_z = int'($urandom_range(0, 524288)) - 262144;
        r.other_x = int'($urandom_range(0, 524288)) - 262144;
        r.other_y = int'($urandom_range(0, 524288)) - 262144;
        r.other_z = int'($urandom_range(0, 524288)) - 262144;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) send_request(make_pair($urandom_range(0, 9)));
  endtask

  task automatic run_directed();
    sbf_in_t r;
    // Zero length at the origin and at the extremes
    send_request('0);
    r = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    send_request(r);
    // Widest separation on every axis, both signs
    r = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    send_request(r);
    r = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    send_request(r);
    // Length exactly the default rest length, along each axis
    send_request('{32'sd65536, 0, 0, 0, 0, 0});
    send_request('{0, -32'sd65536, 0, 0, 0, 0});
    send_request('{0, 0, 0, 0, 0, 32'sd65536});
    // Just beyond and just inside the rest length
    send_request('{32'sd65537, 0, 0, 0, 0, 0});
    send_request('{32'sd65535, 0, 0, 0, 0, 0});
    // Stretched diagonal and compressed diagonal
    send_request('{32'sd196608, -32'sd196608, 32'sd131072, 0, 0, 0});
    send_request('{32'sd100, 32'sd200, -32'sd300, 0, 0, 0});
    // One raw unit apart
    send_request('{0, 0, 0, 32'sd1, 0, 0});
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Directed cases as springs, then as bungees
    run_directed();
    drain();
    write_reg(CFG_MODE, CFG_W'(MODE_BUNGEE));
    run_directed();
    drain();

    set_config(MODE_SPRING, 31'd196608, 31'd131072);
    run_random(105);
    drain();

    // Back the pipeline up while requests keep coming
    set_config(MODE_BUNGEE, 31'd65536, 31'd32768);
    hold_req = 1'b1;
    run_random(130);
    drain();

    set_config(MODE_SPRING, 31'h7FFF_FFFF, 31'd0);
    run_random(95);
    drain();

    set_config(MODE_BUNGEE, 31'd0, 31'd0);
    run_random(60);
    drain();

    set_config(MODE_BUNGEE, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    run_random(80);
    drain();

    // Final stretch with no idling
    set_config(MODE_SPRING, 31'($urandom_range(0, 1048576)),
               31'($urandom_range(0, 1048576)));
    idle_on = 1'b0;
    @(negedge clk);
    out_stall = 1'b0;
    run_random(150);
    drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/sbf_pkg.sv
sv/sbf_sqrt.sv
sv/sbf_div.sv
sv/spring_bungee_force.sv
dv/testbench.sv
